// File: hdl/rsgp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsgp_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOWER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_UPPER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE = 3'd4;

  // CORDIC datapath widths
  localparam int unsigned XY_W = 19;
  localparam int unsigned Z_W  = 18;
  localparam int unsigned CORDIC_STEPS = 14;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 19'sd39797;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // Arctangent of 2^-i as a 16-bit binary angle
  function automatic logic signed [Z_W-1:0] atan_f(input int unsigned step);
    logic signed [Z_W-1:0] t;
    case (step)
      0:       t = 18'sd8192;
      1:       t = 18'sd4836;
      2:       t = 18'sd2555;
      3:       t = 18'sd1297;
      4:       t = 18'sd651;
      5:       t = 18'sd326;
      6:       t = 18'sd163;
      7:       t = 18'sd81;
      8:       t = 18'sd41;
      9:       t = 18'sd20;
      10:      t = 18'sd10;
      11:      t = 18'sd5;
      12:      t = 18'sd3;
      13:      t = 18'sd1;
      default: t = 18'sd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: hdl/rsgp_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module rsgp_cordic_stage #(
  parameter int unsigned FIRST_STEP = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire rsgp_pkg::rot_t rot_i,
  output rsgp_pkg::rot_t     rot_o
);

  rsgp_pkg::rot_t rot_d;
  rsgp_pkg::rot_t rot_q;

  always_comb begin
    rsgp_pkg::rot_t r;
    logic signed [rsgp_pkg::XY_W-1:0] xs;
    logic signed [rsgp_pkg::XY_W-1:0] ys;
    r = rot_i;
    for (int unsigned j = 0; j < rsgp_pkg::STEPS_PER_STAGE; j++) begin
      // floor shifts of the values from before this rotation
      xs = r.x >>> (FIRST_STEP + j);
      ys = r.y >>> (FIRST_STEP + j);
      if (!r.z[rsgp_pkg::Z_W-1]) begin
        r.x = r.x - ys;
        r.y = r.y + xs;
        r.z = r.z - rsgp_pkg::atan_f(FIRST_STEP + j);
      end else begin
        r.x = r.x + ys;
        r.y = r.y - xs;
        r.z = r.z + rsgp_pkg::atan_f(FIRST_STEP + j);
      end
    end
    rot_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

`default_nettype wire

// File: hdl/range_scan_to_grid_points_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one transaction per cycle; eleven register stages (angle, reduction plus
// seven two-step CORDIC stages, magnitude, multiply, output) each hold one item.
// A stalled output only stops the stages behind it up to the first empty one.
// Reset clears all valid bits and loads the configuration registers with their defaults.
module range_scan_to_grid_points_unit #(
  parameter int unsigned IMAGE_SIDE  = 512,
  parameter int unsigned MAX_SAMPLES = 2048
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rsgp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [15:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [10:0]                     sample_index_i,
  input  wire logic [15:0]                     range_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [8:0]                           pixel_col_o,
  output logic [8:0]                           pixel_row_o,
  output logic                                 hit_o
);

  localparam int unsigned NS     = 11;
  localparam int unsigned NCS    = rsgp_pkg::CORDIC_STEPS / rsgp_pkg::STEPS_PER_STAGE;
  localparam int unsigned LAST_C = NCS;
  localparam int unsigned ST_MAG = NCS + 1;
  localparam int unsigned ST_MUL = NCS + 2;
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned PROD_W = 32 + MAG_W;
  localparam int unsigned POS_W  = 20;
  localparam logic signed [POS_W-1:0] HALF_S = POS_W'(IMAGE_SIDE / 2);
  localparam logic signed [POS_W-1:0] SIDE_S = POS_W'(IMAGE_SIDE);
  localparam logic [16:0] MAX_SAMPLES_V = 17'(MAX_SAMPLES);

  // Configuration registers
  logic [15:0] range_lower_q, range_upper_q, start_angle_q, angle_step_q, pixel_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lower_q <= 16'd0;
      range_upper_q <= 16'hFFFF;
      start_angle_q <= 16'd0;
      angle_step_q  <= 16'd0;
      pixel_scale_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsgp_pkg::CFG_RANGE_LOWER: range_lower_q <= cfg_data_i;
        rsgp_pkg::CFG_RANGE_UPPER: range_upper_q <= cfg_data_i;
        rsgp_pkg::CFG_START_ANGLE: start_angle_q <= cfg_data_i;
        rsgp_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i;
        rsgp_pkg::CFG_PIXEL_SCALE: pixel_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or its successor loads
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: beam angle and range window check
  logic [15:0] angle_d, angle_q, range0_q;
  logic        ok_d;
  logic        ok_q   [0:ST_MUL];
  logic [31:0] rs_q   [1:ST_MAG];
  logic        flip_q [1:LAST_C];

  assign angle_d = start_angle_q + {5'd0, sample_index_i} * angle_step_q;
  assign ok_d    = ({6'd0, sample_index_i} < MAX_SAMPLES_V)
                && (range_value_i > range_lower_q)
                && (range_value_i < range_upper_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      angle_q  <= angle_d;
      range0_q <= range_value_i;
      ok_q[0]  <= ok_d;
    end
  end

  // Stage 1 input: fold the angle into the right half plane
  logic signed [16:0] ang_s, red_s;
  logic               flip_d;
  rsgp_pkg::rot_t     rot_in [1:LAST_C];
  rsgp_pkg::rot_t     rot_q  [1:LAST_C];

  always_comb begin
    ang_s  = {angle_q[15], angle_q};
    red_s  = ang_s;
    flip_d = 1'b0;
    if (ang_s > 17'sd16384) begin
      red_s  = ang_s - 17'sd32768;
      flip_d = 1'b1;
    end else if (ang_s < -17'sd16384) begin
      red_s  = ang_s + 17'sd32768;
      flip_d = 1'b1;
    end
  end

  assign rot_in[1] = '{x: rsgp_pkg::CORDIC_X0, y: '0, z: {red_s[16], red_s}};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rs_q[1]   <= 32'(range0_q) * 32'(pixel_scale_q);
      flip_q[1] <= flip_d;
      ok_q[1]   <= ok_q[0];
    end
  end

  for (genvar k = 2; k <= LAST_C; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rs_q[k]   <= rs_q[k-1];
        flip_q[k] <= flip_q[k-1];
        ok_q[k]   <= ok_q[k-1];
      end
    end
  end

  for (genvar g = 1; g <= LAST_C; g++) begin : g_cordic
    if (g > 1) begin : g_link
      assign rot_in[g] = rot_q[g-1];
    end
    rsgp_cordic_stage #(
      .FIRST_STEP(rsgp_pkg::STEPS_PER_STAGE * (g - 1))
    ) u_stage (
      .clk_i (clk_i),
      .en_i  (en[g]),
      .rot_i (rot_in[g]),
      .rot_o (rot_q[g])
    );
  end

  // Magnitude stage: undo the fold, split sign and magnitude
  logic signed [rsgp_pkg::XY_W-1:0] cf, sf, cabs, sabs;
  logic [MAG_W-1:0] magc_q, mags_q;
  logic             negc_q, negs_q;

  always_comb begin
    cf   = flip_q[LAST_C] ? -rot_q[LAST_C].x : rot_q[LAST_C].x;
    sf   = flip_q[LAST_C] ? -rot_q[LAST_C].y : rot_q[LAST_C].y;
    cabs = cf[rsgp_pkg::XY_W-1] ? -cf : cf;
    sabs = sf[rsgp_pkg::XY_W-1] ? -sf : sf;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MAG]) begin
      magc_q       <= cabs[MAG_W-1:0];
      mags_q       <= sabs[MAG_W-1:0];
      negc_q       <= cf[rsgp_pkg::XY_W-1];
      negs_q       <= sf[rsgp_pkg::XY_W-1];
      rs_q[ST_MAG] <= rs_q[LAST_C];
      ok_q[ST_MAG] <= ok_q[LAST_C];
    end
  end

  // Multiply stage: keep the integer pixel part
  logic [PROD_W-1:0] prodc, prods;
  logic [MAG_W-1:0]  pc_q, ps_q;
  logic              negc9_q, negs9_q;

  assign prodc = PROD_W'(rs_q[ST_MAG]) * PROD_W'(magc_q);
  assign prods = PROD_W'(rs_q[ST_MAG]) * PROD_W'(mags_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      pc_q         <= prodc[PROD_W-1:32];
      ps_q         <= prods[PROD_W-1:32];
      negc9_q      <= negc_q;
      negs9_q      <= negs_q;
      ok_q[ST_MUL] <= ok_q[ST_MAG];
    end
  end

  // Output stage: center, bound check, register
  logic signed [POS_W-1:0] offc, offs, colv, rowv;
  logic                    hit_d;

  always_comb begin
    offc  = negc9_q ? -$signed({3'd0, pc_q}) : $signed({3'd0, pc_q});
    offs  = negs9_q ? -$signed({3'd0, ps_q}) : $signed({3'd0, ps_q});
    colv  = offc + HALF_S;
    rowv  = offs + HALF_S;
    hit_d = ok_q[ST_MUL]
         && !colv[POS_W-1] && (colv < SIDE_S)
         && !rowv[POS_W-1] && (rowv < SIDE_S);
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      hit_o       <= hit_d;
      pixel_col_o <= hit_d ? colv[8:0] : 9'd0;
      pixel_row_o <= hit_d ? rowv[8:0] : 9'd0;
    end
  end

  assign out_valid_o = v_q[NS-1];

`ifndef SYNTHESIS
  // A missed point carries a zero coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (pixel_col_o == 9'd0 && pixel_row_o == 9'd0))
    else $error("miss result with nonzero coordinate");

  // Input back-pressure only when every stage holds an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled while a stage is empty");

  // A held stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_MAG] && !en[ST_MAG]) |=> v_q[ST_MAG])
    else $error("held stage lost its item");

  // Output drains only through the consumer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IMAGE_SIDE   = 512;
  localparam int unsigned MAX_SAMPLES  = 2048;
  localparam int unsigned PIPE_LATENCY = 10;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDX_W        = rsgp_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] CFG_SPARE_LAST = '1;

  typedef struct packed {
    logic [8:0] col;
    logic [8:0] row;
    logic       hit;
  } grid_point_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  class grid_point_board;
    logic [15:0]  floor_q88;
    logic [15:0]  ceiling_q88;
    logic [15:0]  base_angle;
    logic [15:0]  angle_inc;
    logic [15:0]  px_per_m;
    grid_point_t  expected_points[$];
    int unsigned  error_count;

    function new();
      floor_q88   = 16'd0;
      ceiling_q88 = 16'd65535;
      base_angle  = 16'd0;
      angle_inc   = 16'd0;
      px_per_m    = 16'd256;
      error_count = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        rsgp_pkg::CFG_RANGE_LOWER: floor_q88   = data;
        rsgp_pkg::CFG_RANGE_UPPER: ceiling_q88 = data;
        rsgp_pkg::CFG_START_ANGLE: base_angle  = data;
        rsgp_pkg::CFG_ANGLE_STEP:  angle_inc   = data;
        rsgp_pkg::CFG_PIXEL_SCALE: px_per_m    = data;
        default: ;
      endcase
    endfunction

    // Range times scale times |trig|, dropped 32 fraction bits, sign restored.
    function longint axis_offset(logic [15:0] rng, longint trig);
      longint mag;
      longint p;
      mag = (trig < 0) ? -trig : trig;
      p = (longint'(rng) * longint'(px_per_m) * mag) >>> 32;
      return (trig < 0) ? -p : p;
    endfunction

    function void project_sample(logic [10:0] idx, logic [15:0] rng);
      logic [15:0] beam;
      longint      a;
      longint      x;
      longint      y;
      longint      z;
      longint      xs;
      longint      ys;
      longint      t;
      longint      col;
      longint      row;
      bit          flip;
      bit          hit;
      grid_point_t pt;
      beam = base_angle + idx * angle_inc;
      a = longint'(beam);
      if (a >= 32768) a -= 65536;
      flip = 1'b0;
      // Fold the back half-circle onto the front and negate afterwards
      if (a > 16384) begin
        a -= 32768;
        flip = 1'b1;
      end else if (a < -16384) begin
        a += 32768;
        flip = 1'b1;
      end
      x = 39797;
      y = 0;
      z = a;
      for (int i = 0; i < 14; i++) begin
        case (i)
          0:       t = 8192;
          1:       t = 4836;
          2:       t = 2555;
          3:       t = 1297;
          4:       t = 651;
          5:       t = 326;
          6:       t = 163;
          7:       t = 81;
          8:       t = 41;
          9:       t = 20;
          10:      t = 10;
          11:      t = 5;
          12:      t = 3;
          default: t = 1;
        endcase
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= t;
        end else begin
          x += ys;
          y -= xs;
          z += t;
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      col = axis_offset(rng, x) + longint'(IMAGE_SIDE / 2);
      row = axis_offset(rng, y) + longint'(IMAGE_SIDE / 2);
      hit = (idx < MAX_SAMPLES) && (rng > floor_q88) && (rng < ceiling_q88)
          && (col >= 0) && (col < longint'(IMAGE_SIDE))
          && (row >= 0) && (row < longint'(IMAGE_SIDE));
      pt.hit = hit;
      pt.col = hit ? col[8:0] : 9'd0;
      pt.row = hit ? row[8:0] : 9'd0;
      expected_points = {expected_points, pt};
    endfunction

    task report(string msg);
      $display("testbench: mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task compare_point(logic [8:0] col, logic [8:0] row, logic hit);
      grid_point_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected point col=%0d row=%0d hit=%0d", col, row, hit));
        return;
      end
      want = expected_points.pop_front();
      if (hit !== want.hit)
        report($sformatf("hit %0d, expected %0d", hit, want.hit));
      if (col !== want.col)
        report($sformatf("pixel_col %0d, expected %0d", col, want.col));
      if (row !== want.row)
        report($sformatf("pixel_row %0d, expected %0d", row, want.row));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IDX_W-1:0]     cfg_idx_i;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [10:0]          sample_index_i;
  logic [15:0]          range_value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [8:0]           pixel_col_o;
  logic [8:0]           pixel_row_o;
  logic                 hit_o;

  grid_point_board board;
  int unsigned     burst_left;
  int unsigned     cycle_count;
  bit              hold_off_request;
  bit              hold_off_done;

  range_scan_to_grid_points_unit #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_index_i(sample_index_i),
    .range_value_i (range_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o),
    .hit_o         (hit_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.compare_point(pixel_col_o, pixel_row_o, hit_o);
  end

  // Output side backpressure: segments of differing stall patterns, plus one long hold
  initial begin
    int unsigned seg;
    int unsigned k;
    ready_mode_e mode;
    out_ready_i = 1'b0;
    forever begin
      seg  = $urandom_range(5, 60);
      mode = ready_mode_e'($urandom_range(0, 3));
      for (k = 0; k < seg; k++) begin
        @(negedge clk_i);
        if (hold_off_request) begin
          out_ready_i = 1'b0;
          hold_off_request = 1'b0;
          repeat (LONG_HOLD - 1) @(negedge clk_i);
        end else begin
          case (mode)
            READY_ALWAYS:   out_ready_i = 1'b1;
            READY_COIN:     out_ready_i = 1'($urandom_range(0, 1));
            READY_SPARSE:   out_ready_i = ($urandom_range(0, 3) == 0);
            READY_PERIODIC: out_ready_i = (k % 4 != 0);
            default:        out_ready_i = 1'b1;
          endcase
        end
      end
    end
  end

  task automatic push_sample(input logic [10:0] idx, input logic [15:0] rng);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i     = 1'b1;
    sample_index_i = idx;
    range_value_i  = rng;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    board.project_sample(idx, rng);
  endtask

  // Drop valid, wait out every pending point, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (board.expected_points.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    board.write_register(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] base, input logic [15:0] inc,
                               input logic [15:0] scale);
    logic [IDX_W-1:0] spare;
    settle();
    write_register(rsgp_pkg::CFG_RANGE_LOWER, lo);
    write_register(rsgp_pkg::CFG_RANGE_UPPER, hi);
    write_register(rsgp_pkg::CFG_START_ANGLE, base);
    write_register(rsgp_pkg::CFG_ANGLE_STEP, inc);
    write_register(rsgp_pkg::CFG_PIXEL_SCALE, scale);
    // Unmapped index: must leave every register untouched
    spare = IDX_W'($urandom_range(int'(rsgp_pkg::CFG_PIXEL_SCALE) + 1, int'(CFG_SPARE_LAST)));
    write_register(spare, 16'($urandom));
  endtask

  // Mostly contiguous scan runs with ranges that land in the image, some noise
  task automatic scan_phase(input int unsigned count);
    int unsigned n;
    int unsigned reach;
    int unsigned pick;
    logic [10:0] idx;
    logic [15:0] rng;
    if (board.px_per_m == 0) reach = 65535;
    else begin
      reach = (300 << 16) / board.px_per_m;
      if (reach > 65535) reach = 65535;
    end
    idx = 11'($urandom_range(0, 2047));
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 7) idx = idx + 11'd1;
      else idx = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 9);
      if (pick < 6)       rng = 16'($urandom_range(0, reach));
      else if (pick < 8)  rng = 16'($urandom_range(0, 65535));
      else if (pick == 8) rng = board.floor_q88 + 16'($urandom_range(0, 1));
      else                rng = board.ceiling_q88 - 16'($urandom_range(0, 1));
      if (!hold_off_done && n == count / 2) begin
        hold_off_request = 1'b1;
        hold_off_done = 1'b1;
      end
      push_sample(idx, rng);
    end
  endtask

  initial begin
    board            = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = rsgp_pkg::CFG_RANGE_LOWER;
    cfg_data_i       = 16'd0;
    in_valid_i       = 1'b0;
    sample_index_i   = 11'd0;
    range_value_i    = 16'd0;
    burst_left       = 0;
    cycle_count      = 0;
    hold_off_request = 1'b0;
    hold_off_done    = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Registers at their reset values: beam fixed at zero angle
    push_sample(11'd0, 16'd0);
    push_sample(11'd2047, 16'd65535);
    push_sample(11'd5, 16'd1);
    push_sample(11'd100, 16'd25600);
    push_sample(11'd1, 16'd32768);
    push_sample(11'd2047, 16'd65534);

    // Angle = index * 32: walk the quadrant folds and the half-circle point
    apply_setting(16'd0, 16'd65535, 16'd0, 16'd32, 16'd256);
    push_sample(11'd0, 16'd25600);
    push_sample(11'd256, 16'd25600);
    push_sample(11'd511, 16'd25600);
    push_sample(11'd512, 16'd25600);
    push_sample(11'd513, 16'd25600);
    push_sample(11'd768, 16'd25600);
    push_sample(11'd1023, 16'd25600);
    push_sample(11'd1024, 16'd25600);
    push_sample(11'd1025, 16'd25600);
    push_sample(11'd1535, 16'd25600);
    push_sample(11'd1536, 16'd25600);
    push_sample(11'd1537, 16'd25600);
    push_sample(11'd0, 16'd65534);
    push_sample(11'd512, 16'd65534);
    push_sample(11'd1024, 16'd65534);
    push_sample(11'd1, 16'd0);
    push_sample(11'd3, 16'd65535);

    for (int k = 0; k < 7; k++) begin
      case (k)
        0: apply_setting(16'd256, 16'd40000, 16'($urandom), 16'($urandom),
                         16'($urandom_range(64, 2048)));
        1: apply_setting(16'd0, 16'd65535, 16'h8000, 16'h7FFF, 16'hFFFF);
        2: apply_setting(16'd1000, 16'd60000, 16'h7FFF, 16'h8000, 16'd0);
        3: apply_setting(16'd40000, 16'd40000, 16'($urandom), 16'($urandom), 16'd256);
        4: apply_setting(16'd65535, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
        default: apply_setting(16'($urandom_range(0, 2000)), 16'($urandom_range(30000, 65535)),
                               16'($urandom), 16'($urandom),
                               16'($urandom_range(16, 4096)));
      endcase
      scan_phase(60);
    end

    settle();
    if (board.error_count == 0 && board.expected_points.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/rsgp_pkg.sv
hdl/rsgp_cordic_stage.sv
hdl/range_scan_to_grid_points_unit.sv
tb/testbench.sv
